FILE: hdl/odbp_pkg.sv
// Shared types and constants for the ordered-dither bit packer.
// Holds the register index codes, the clamped-region struct and the 4x4 threshold table.
// No dependencies.
package odbp_pkg;

	localparam int unsigned MAX_DIM   = 4096;
	localparam int unsigned DIM_W     = 13;
	localparam int unsigned REQ_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REQ_LEFT    = 3'd0,
		REG_REQ_TOP     = 3'd1,
		REG_REQ_RIGHT   = 3'd2,
		REG_REQ_BOTTOM  = 3'd3,
		REG_CLIP_LEFT   = 3'd4,
		REG_CLIP_TOP    = 3'd5,
		REG_CLIP_RIGHT  = 3'd6,
		REG_CLIP_BOTTOM = 3'd7
	} cfg_reg_t;

	// Clamped region as seen by the pixel walk
	typedef struct packed {
		logic             empty;
		logic [1:0]       left_phase;
		logic [1:0]       top_phase;
		logic [DIM_W-1:0] last_col_idx;
		logic [DIM_W-1:0] last_row_idx;
	} region_t;

	localparam logic [7:0] THR_TABLE [16] = '{
		8'd0,   8'd136, 8'd34,  8'd170,
		8'd68,  8'd204, 8'd102, 8'd238,
		8'd51,  8'd187, 8'd17,  8'd153,
		8'd119, 8'd255, 8'd85,  8'd221
	};

	function automatic logic [7:0] dither_thr(input logic [1:0] row_ph, input logic [1:0] col_ph);
		dither_thr = THR_TABLE[{row_ph, col_ph}];
	endfunction

endpackage

FILE: hdl/odbp_region.sv
// Clamps the requested rectangle to the clip box.
// Produces emptiness, start phases and last column/row indexes; uses odbp_pkg.
module odbp_region import odbp_pkg::*; (
	input  logic [REQ_W-1:0] req_left,
	input  logic [REQ_W-1:0] req_top,
	input  logic [REQ_W-1:0] req_right,
	input  logic [REQ_W-1:0] req_bottom,
	input  logic [DIM_W-1:0] clip_left,
	input  logic [DIM_W-1:0] clip_top,
	input  logic [DIM_W-1:0] clip_right,
	input  logic [DIM_W-1:0] clip_bottom,
	output region_t          region
);

	localparam logic signed [REQ_W:0] MAX_S = (REQ_W+1)'(MAX_DIM);

	logic signed [REQ_W:0] cl_s, ct_s, cr_s, cb_s;
	logic signed [REQ_W:0] rl_s, rt_s, rr_s, rb_s;
	logic signed [REQ_W:0] l_s, t_s, r_s, b_s;
	logic signed [REQ_W:0] w_s, h_s;

	function automatic logic signed [REQ_W:0] sat_clip(input logic [DIM_W-1:0] v);
		logic signed [REQ_W:0] ext;
		ext = $signed({{(REQ_W+1-DIM_W){1'b0}}, v});
		sat_clip = (ext > MAX_S) ? MAX_S : ext;
	endfunction

	always_comb begin
		cl_s = sat_clip(clip_left);
		ct_s = sat_clip(clip_top);
		cr_s = sat_clip(clip_right) - 17'sd1;
		cb_s = sat_clip(clip_bottom) - 17'sd1;
		rl_s = $signed({req_left[REQ_W-1], req_left});
		rt_s = $signed({req_top[REQ_W-1], req_top});
		rr_s = $signed({req_right[REQ_W-1], req_right});
		rb_s = $signed({req_bottom[REQ_W-1], req_bottom});
		l_s  = (rl_s < cl_s) ? cl_s : rl_s;
		t_s  = (rt_s < ct_s) ? ct_s : rt_s;
		r_s  = (rr_s > cr_s) ? cr_s : rr_s;
		b_s  = (rb_s > cb_s) ? cb_s : rb_s;
		w_s  = r_s - l_s;
		h_s  = b_s - t_s;
		region.empty        = (r_s < l_s) || (b_s < t_s);
		region.left_phase   = l_s[1:0];
		region.top_phase    = t_s[1:0];
		region.last_col_idx = w_s[DIM_W-1:0];
		region.last_row_idx = h_s[DIM_W-1:0];
	end

endmodule

FILE: hdl/ordered_dither_bit_packer.sv
// Top level of the ordered-dither bit packer: config registers, pixel walk and byte output register.
// Depends on odbp_pkg and odbp_region.
//
// Usage:
//  - Write the requested rectangle (signed) and clip box through cfg_we/cfg_index/cfg_data
//    while the stream is idle. Any write restarts the walk at the top-left of the new region
//    and drops a partial byte.
//  - Feed one red level per pixel of the clamped region on s_tdata, raster order.
//    Each pixel is compared with a 4x4 ordered threshold; bits pack MSB first.
//  - A byte leaves on m_tdata after 8 pixels or at row end (tail zero padded).
//    m_tuser flags the last byte of a row, m_tlast the last byte of the region.
//  - One pixel per clock while s_tready is high. A byte is valid in the cycle after the
//    transaction of the pixel that completes it; the compare, pack and count update sit
//    between the input handshake and the output register.
//  - If the clamped region is empty, pixels are accepted and dropped.
//  - When the receiver stalls, the byte holds in the output register; s_tready stays high
//    as long as that register is empty or being taken in the same cycle.
//  - Reset: request corners clear to 0, clip box to 0..4096, walk at top-left, output empty.
module ordered_dither_bit_packer import odbp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REQ_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] red_level
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] packed_bits
	output logic                 m_tuser,   // [0] row_end
	output logic                 m_tlast    // region_end
);

	logic [REQ_W-1:0] req_left_q, req_top_q, req_right_q, req_bottom_q;
	logic [DIM_W-1:0] clip_left_q, clip_top_q, clip_right_q, clip_bottom_q;

	logic [DIM_W-1:0] col_count_q, row_count_q;
	logic [2:0]       bit_slot_q;
	logic [7:0]       byte_accum_q;

	logic       out_valid_q;
	logic [7:0] out_bits_q;
	logic       out_row_end_q, out_region_end_q;

	region_t    region;
	logic       take;
	logic       pix_bit;
	logic [7:0] accum_next;
	logic       last_col, last_row, emit;
	logic [1:0] col_phase, row_phase;

	odbp_region u_region (
		.req_left    (req_left_q),
		.req_top     (req_top_q),
		.req_right   (req_right_q),
		.req_bottom  (req_bottom_q),
		.clip_left   (clip_left_q),
		.clip_top    (clip_top_q),
		.clip_right  (clip_right_q),
		.clip_bottom (clip_bottom_q),
		.region      (region)
	);

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready && !region.empty;

	// Phases restart at the clamped edges, so derive them from the counters
	assign col_phase = region.left_phase + col_count_q[1:0];
	assign row_phase = region.top_phase + row_count_q[1:0];

	always_comb begin
		pix_bit    = s_tdata > dither_thr(row_phase, col_phase);
		accum_next = byte_accum_q | ({7'd0, pix_bit} << bit_slot_q);
		last_col   = col_count_q >= region.last_col_idx;
		last_row   = row_count_q >= region.last_row_idx;
		emit       = (bit_slot_q == 3'd0) || last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_left_q    <= '0;
			req_top_q     <= '0;
			req_right_q   <= '0;
			req_bottom_q  <= '0;
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_right_q  <= DIM_W'(MAX_DIM);
			clip_bottom_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_REQ_LEFT:    req_left_q    <= cfg_data;
				REG_REQ_TOP:     req_top_q     <= cfg_data;
				REG_REQ_RIGHT:   req_right_q   <= cfg_data;
				REG_REQ_BOTTOM:  req_bottom_q  <= cfg_data;
				REG_CLIP_LEFT:   clip_left_q   <= cfg_data[DIM_W-1:0];
				REG_CLIP_TOP:    clip_top_q    <= cfg_data[DIM_W-1:0];
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_data[DIM_W-1:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q  <= '0;
			row_count_q  <= '0;
			bit_slot_q   <= 3'd7;
			byte_accum_q <= '0;
		end else if (cfg_we) begin
			// restart the walk and drop a partial byte
			col_count_q  <= '0;
			row_count_q  <= '0;
			bit_slot_q   <= 3'd7;
			byte_accum_q <= '0;
		end else if (take) begin
			if (emit) begin
				byte_accum_q <= '0;
				bit_slot_q   <= 3'd7;
				if (last_col) begin
					col_count_q <= '0;
					row_count_q <= last_row ? '0 : row_count_q + 1'b1;
				end else begin
					col_count_q <= col_count_q + 1'b1;
				end
			end else begin
				byte_accum_q <= accum_next;
				bit_slot_q   <= bit_slot_q - 1'b1;
				col_count_q  <= col_count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_bits_q       <= accum_next;
			out_row_end_q    <= last_col;
			out_region_end_q <= last_col && last_row;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_bits_q;
	assign m_tuser  = out_row_end_q;
	assign m_tlast  = out_region_end_q;

endmodule
